@@ design/crbs_pkg.sv @@
`default_nettype none

package crbs_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic plan;
      logic issue;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pend_any;
      logic out_free;
      logic last_press;
   } ctrl_sts_type;

   localparam logic CMD_MOVE   = 1'b0;
   localparam logic CMD_RESYNC = 1'b1;

   localparam logic [1:0] MODE_COOL = 2'd0;
   localparam logic [1:0] MODE_DRY  = 2'd1;
   localparam logic [1:0] MODE_FAN  = 2'd2;

   localparam logic [2:0] BTN_POWER = 3'd0;
   localparam logic [2:0] BTN_MODE  = 3'd1;
   localparam logic [2:0] BTN_UP    = 3'd2;
   localparam logic [2:0] BTN_DOWN  = 3'd3;
   localparam logic [2:0] BTN_FAN   = 3'd4;

   localparam logic REG_TEMP_LOWEST  = 1'b0;
   localparam logic REG_TEMP_HIGHEST = 1'b1;

   localparam logic [5:0] TEMP_LOWEST_RESET  = 6'd15;
   localparam logic [5:0] TEMP_HIGHEST_RESET = 6'd30;

   localparam logic       DEF_POWER = 1'b1;
   localparam logic [1:0] DEF_MODE  = MODE_COOL;
   localparam logic [5:0] DEF_TEMP  = 6'd25;
   localparam logic       DEF_FAN   = 1'b0;

   localparam logic [4:0] MAX_TEMP_PRESSES = 5'd30;

endpackage

`default_nettype wire

@@ design/crbs_req_if.sv @@
`default_nettype none

interface crbs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic       desired_power;
   logic [1:0] desired_mode;
   logic [6:0] target_temp_half;
   logic       desired_fan;

   modport source (output valid, command, desired_power, desired_mode, target_temp_half,
                   desired_fan, input ready);
   modport sink (input valid, command, desired_power, desired_mode, target_temp_half,
                 desired_fan, output ready);
endinterface

`default_nettype wire

@@ design/crbs_rsp_if.sv @@
`default_nettype none

interface crbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] button;
   logic       last;

   modport source (output valid, button, last, input ready);
   modport sink (input valid, button, last, output ready);
endinterface

`default_nettype wire

@@ design/climate_remote_button_sequencer_core.sv @@
// Channel   Direction  Handshake             Carries
// req_chan  in         valid/ready           command, target power/mode/temp/fan
// rsp_chan  out        valid/ready           button, last
// csr_*     in         csr_wr_en, no stall   temp_lowest (0), temp_highest (1)
//
// A request is captured, planned, then emits its n presses (at most 33), one press per cycle
// while the result side keeps up; a request with no presses still passes through the emit state.
// One request is planned at a time; the next is taken after its final press
// is loaded into the output register. Reset is synchronous and restores the
// limits and the believed unit state. A stalled result holds the press walk.
`default_nettype none

module climate_remote_button_sequencer_core (
   input  wire       clock,
   input  wire       reset,
   crbs_req_if.sink  req_chan,
   crbs_rsp_if.source rsp_chan,
   input  wire       csr_wr_en,
   input  wire       csr_index,
   input  wire [5:0] csr_wr_data
);

   crbs_pkg::ctrl_cmd_type cmd;
   crbs_pkg::ctrl_sts_type sts;

   crbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   crbs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .in_command          (req_chan.command),
      .in_desired_power    (req_chan.desired_power),
      .in_desired_mode     (req_chan.desired_mode),
      .in_target_temp_half (req_chan.target_temp_half),
      .in_desired_fan      (req_chan.desired_fan),
      .out_valid           (rsp_chan.valid),
      .out_ready           (rsp_chan.ready),
      .out_button          (rsp_chan.button),
      .out_last            (rsp_chan.last),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

`default_nettype wire

@@ design/crbs_ctrl.sv @@
`default_nettype none

module crbs_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  crbs_pkg::ctrl_sts_type sts,
   output crbs_pkg::ctrl_cmd_type cmd
);

   crbs_pkg::state_type state_ff;
   crbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.plan    = 1'b0;
      cmd.issue   = 1'b0;
      case (state_ff)
         crbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = crbs_pkg::ST_PLAN;
            end
         end
         crbs_pkg::ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = crbs_pkg::ST_EMIT;
         end
         crbs_pkg::ST_EMIT: begin
            if (!sts.pend_any) begin
               state_in = crbs_pkg::ST_IDLE;
            end else if (sts.out_free) begin
               cmd.issue = 1'b1;
               if (sts.last_press) begin
                  state_in = crbs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = crbs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/crbs_datapath.sv @@
`default_nettype none

module crbs_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_wr_en,
   input  wire                    csr_index,
   input  wire  [5:0]             csr_wr_data,
   input  wire                    in_command,
   input  wire                    in_desired_power,
   input  wire  [1:0]             in_desired_mode,
   input  wire  [6:0]             in_target_temp_half,
   input  wire                    in_desired_fan,
   output logic                   out_valid,
   input  wire                    out_ready,
   output logic [2:0]             out_button,
   output logic                   out_last,
   input  crbs_pkg::ctrl_cmd_type cmd,
   output crbs_pkg::ctrl_sts_type sts
);

   // Configuration.
   logic [5:0] temp_lowest_ff;
   logic [5:0] temp_highest_ff;

   // Believed unit state.
   logic       power_ff, power_in;
   logic [1:0] mode_ff, mode_in;
   logic [5:0] temp_ff, temp_in;
   logic       fan_ff, fan_in;

   // Captured request.
   logic       cmd_ff;
   logic       tpow_ff;
   logic [1:0] tmode_ff;
   logic [6:0] ttemp_ff;
   logic       tfan_ff;

   // Presses still to emit.
   logic       pwr_pend_ff, pwr_pend_in;
   logic [1:0] mode_cnt_ff, mode_cnt_in;
   logic [4:0] temp_cnt_ff, temp_cnt_in;
   logic       temp_up_ff, temp_up_in;
   logic       fan_pend_ff, fan_pend_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] button_ff, button_in;
   logic       last_ff, last_in;
   logic       last_press;

   // Planning arithmetic.
   logic [6:0] lo_half;
   logic [6:0] hi_half;
   logic [6:0] t_clip_hi;
   logic [6:0] t_clamped;
   logic [7:0] diff;
   logic       diff_up;
   logic [7:0] diff_mag;
   logic [7:0] mag_round;
   logic [6:0] steps_raw;
   logic [4:0] steps;
   logic [5:0] temp_next;
   logic [2:0] ring_steps;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_lowest_ff  <= crbs_pkg::TEMP_LOWEST_RESET;
         temp_highest_ff <= crbs_pkg::TEMP_HIGHEST_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == crbs_pkg::REG_TEMP_LOWEST) begin
            temp_lowest_ff <= csr_wr_data;
         end else begin
            temp_highest_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= in_command;
         tpow_ff  <= in_desired_power;
         tmode_ff <= in_desired_mode;
         ttemp_ff <= in_target_temp_half;
         tfan_ff  <= in_desired_fan;
      end
   end

   // Clamp down to the upper limit first, then up to the lower one.
   always_comb begin
      lo_half    = {temp_lowest_ff, 1'b0};
      hi_half    = {temp_highest_ff, 1'b0};
      t_clip_hi  = (ttemp_ff > hi_half) ? hi_half : ttemp_ff;
      t_clamped  = (t_clip_hi < lo_half) ? lo_half : t_clip_hi;
      diff       = {1'b0, t_clamped} - {1'b0, temp_ff, 1'b0};
      diff_up    = ~diff[7];
      diff_mag   = diff_up ? diff : (8'd0 - diff);
      mag_round  = diff_mag + 8'd1;
      steps_raw  = mag_round[7:1];
      steps      = (steps_raw > {2'b00, crbs_pkg::MAX_TEMP_PRESSES}) ?
                   crbs_pkg::MAX_TEMP_PRESSES : steps_raw[4:0];
      temp_next  = diff_up ? (temp_ff + {1'b0, steps}) : (temp_ff - {1'b0, steps});
      if (tmode_ff >= mode_ff) begin
         ring_steps = {1'b0, tmode_ff} - {1'b0, mode_ff};
      end else begin
         ring_steps = {1'b0, tmode_ff} + 3'd3 - {1'b0, mode_ff};
      end
   end

   always_comb begin
      power_in     = power_ff;
      mode_in      = mode_ff;
      temp_in      = temp_ff;
      fan_in       = fan_ff;
      pwr_pend_in  = pwr_pend_ff;
      mode_cnt_in  = mode_cnt_ff;
      temp_cnt_in  = temp_cnt_ff;
      temp_up_in   = temp_up_ff;
      fan_pend_in  = fan_pend_ff;
      rsp_valid_in = out_ready ? 1'b0 : rsp_valid_ff;
      button_in    = button_ff;
      last_in      = last_ff;
      last_press   = 1'b0;

      if (cmd.plan) begin
         pwr_pend_in = 1'b0;
         mode_cnt_in = 2'd0;
         temp_cnt_in = 5'd0;
         temp_up_in  = 1'b0;
         fan_pend_in = 1'b0;
         if (cmd_ff == crbs_pkg::CMD_RESYNC) begin
            power_in = crbs_pkg::DEF_POWER;
            mode_in  = crbs_pkg::DEF_MODE;
            temp_in  = crbs_pkg::DEF_TEMP;
            fan_in   = crbs_pkg::DEF_FAN;
         end else begin
            pwr_pend_in = (power_ff != tpow_ff);
            power_in    = tpow_ff;
            if (tpow_ff) begin
               mode_in = tmode_ff;
               // A mode outside the ring is adopted without any presses.
               if (mode_ff != tmode_ff && mode_ff != 2'd3 && tmode_ff != 2'd3) begin
                  mode_cnt_in = ring_steps[1:0];
               end
               if (tmode_ff == crbs_pkg::MODE_COOL) begin
                  temp_cnt_in = steps;
                  temp_up_in  = diff_up;
                  temp_in     = temp_next;
               end
               if (tmode_ff == crbs_pkg::MODE_FAN && fan_ff != tfan_ff) begin
                  fan_pend_in = 1'b1;
                  fan_in      = tfan_ff;
               end
            end
         end
      end

      if (pwr_pend_ff) begin
         button_in  = crbs_pkg::BTN_POWER;
         last_press = (mode_cnt_ff == 2'd0) && (temp_cnt_ff == 5'd0) && !fan_pend_ff;
      end else if (mode_cnt_ff != 2'd0) begin
         button_in  = crbs_pkg::BTN_MODE;
         last_press = (mode_cnt_ff == 2'd1) && (temp_cnt_ff == 5'd0) && !fan_pend_ff;
      end else if (temp_cnt_ff != 5'd0) begin
         button_in  = temp_up_ff ? crbs_pkg::BTN_UP : crbs_pkg::BTN_DOWN;
         last_press = (temp_cnt_ff == 5'd1) && !fan_pend_ff;
      end else begin
         button_in  = crbs_pkg::BTN_FAN;
         last_press = 1'b1;
      end
      last_in = last_press;

      if (cmd.issue) begin
         rsp_valid_in = 1'b1;
         if (pwr_pend_ff) begin
            pwr_pend_in = 1'b0;
         end else if (mode_cnt_ff != 2'd0) begin
            mode_cnt_in = mode_cnt_ff - 2'd1;
         end else if (temp_cnt_ff != 5'd0) begin
            temp_cnt_in = temp_cnt_ff - 5'd1;
         end else begin
            fan_pend_in = 1'b0;
         end
      end else begin
         button_in = button_ff;
         last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff     <= crbs_pkg::DEF_POWER;
         mode_ff      <= crbs_pkg::DEF_MODE;
         temp_ff      <= crbs_pkg::DEF_TEMP;
         fan_ff       <= crbs_pkg::DEF_FAN;
         pwr_pend_ff  <= 1'b0;
         mode_cnt_ff  <= 2'd0;
         temp_cnt_ff  <= 5'd0;
         temp_up_ff   <= 1'b0;
         fan_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         power_ff     <= power_in;
         mode_ff      <= mode_in;
         temp_ff      <= temp_in;
         fan_ff       <= fan_in;
         pwr_pend_ff  <= pwr_pend_in;
         mode_cnt_ff  <= mode_cnt_in;
         temp_cnt_ff  <= temp_cnt_in;
         temp_up_ff   <= temp_up_in;
         fan_pend_ff  <= fan_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      button_ff <= button_in;
      last_ff   <= last_in;
   end

   assign sts.pend_any = pwr_pend_ff || (mode_cnt_ff != 2'd0) || (temp_cnt_ff != 5'd0) ||
                         fan_pend_ff;
   assign sts.out_free = !rsp_valid_ff || out_ready;
   assign sts.last_press = last_press;

   assign out_valid  = rsp_valid_ff;
   assign out_button = button_ff;
   assign out_last   = last_ff;

endmodule

`default_nettype wire

@@ design/crbs_checker.sv @@
`default_nettype none

module crbs_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_button,
   input wire       rsp_last
);

   // A held result keeps its press.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_button) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_button_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_button <= crbs_pkg::BTN_FAN)
      else $error("undefined button code");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Planning takes the cycle after a request is accepted.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during planning");

endmodule

bind climate_remote_button_sequencer_core crbs_checker u_crbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_button (rsp_chan.button),
   .rsp_last   (rsp_chan.last)
);

`default_nettype wire
